FILE: src/neuron_dot_product_activation_defines.svh
// ----------------------------------------------------------------------------
// neuron_dot_product_activation_defines
// Assertion macros used by the neuron back end module (ndpa_back).
// ----------------------------------------------------------------------------
`ifndef NEURON_DOT_PRODUCT_ACTIVATION_DEFINES_SVH
`define NEURON_DOT_PRODUCT_ACTIVATION_DEFINES_SVH

// same-cycle implication
`define NDPA_ASSERT_IMPL(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("ndpa check failed");

// next-cycle implication
`define NDPA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("ndpa check failed");

`endif

FILE: src/ndpa_pkg.sv
// ----------------------------------------------------------------------------
// ndpa_pkg
// Types, constants and table builders for the neuron dot product block.
// ----------------------------------------------------------------------------
package ndpa_pkg;

   // default parameter values
   localparam int FRAC_BITS_DEF        = 12;
   localparam int TABLE_INDEX_BITS_DEF = 10;
   localparam int QUEUE_DEPTH_DEF      = 4;

   // fixed field widths
   localparam int VAL_W  = 16;
   localparam int PROD_W = 32;
   localparam int ACC_W  = 48;

   // register indexes (paddr bit 2)
   localparam logic REG_MODE = 1'b0;
   localparam logic REG_BIAS = 1'b1;

   // activation select
   typedef enum logic [1:0] {
      MODE_SIGMOID  = 2'd0,
      MODE_STEP     = 2'd1,
      MODE_TANH     = 2'd2,
      MODE_IDENTITY = 2'd3
   } ndpa_mode_type;

   // configuration handed to the back end
   typedef struct packed {
      ndpa_mode_type      mode;
      logic signed [15:0] bias;
   } ndpa_cfg_type;

   // one queued product
   typedef struct packed {
      logic signed [PROD_W-1:0] prod;
      logic                     last;
   } ndpa_entry_type;

   // queue status
   typedef struct packed {
      logic full;
      logic empty;
   } ndpa_qstat_type;

   // unsigned shift-subtract division, elaboration only
   function automatic logic [63:0] ndpa_udiv(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // (x * y) >> 62 rounded, from 32-bit partial products
   function automatic logic [63:0] ndpa_mul62(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] xl, xh, yl, yh, ll, lh, hl, hh, mid, lo, hi;
      xl  = {32'd0, x[31:0]};
      xh  = {32'd0, x[63:32]};
      yl  = {32'd0, y[31:0]};
      yh  = {32'd0, y[63:32]};
      ll  = xl * yl;
      lh  = xl * yh;
      hl  = xh * yl;
      hh  = xh * yh;
      mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
      lo  = {mid[31:0], ll[31:0]};
      hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
      return ((hi << 2) | (lo >> 62)) + {63'd0, lo[61]};
   endfunction

   // e^(-n / 2^frac) with 40 fraction bits
   function automatic logic [63:0] ndpa_exp_neg(input logic [63:0] n, input int frac);
      logic [63:0] term, base, r;
      term = 64'd1 << 62;
      base = 64'd1 << 62;
      r    = 64'd1 << 62;
      for (int k = 1; k < 40; k++) begin
         if (term != 64'd0) begin
            term = ndpa_udiv(term >> frac, 64'(k));
            base = (k % 2 == 1) ? base - term : base + term;
         end
      end
      for (int b = 0; b < 18; b++) begin
         if (n[b]) begin
            r = ndpa_mul62(r, base);
         end
         base = ndpa_mul62(base, base);
      end
      return (r + (64'd1 << 21)) >> 22;
   endfunction

   // clamp to the positive 16-bit range
   function automatic logic [15:0] ndpa_clamp_pos(input logic [63:0] v);
      return (v > 64'd32767) ? 16'h7FFF : v[15:0];
   endfunction

   // one table entry at the center of segment idx; use_tanh selects tanh
   function automatic logic [15:0] ndpa_rom_entry(input int idx, input logic use_tanh,
                                                   input int frac, input int tib);
      logic [15:0]        pat;
      logic signed [63:0] c;
      logic [63:0]        mag, e, d, s, t;
      logic [15:0]        res;
      pat = 16'(idx << (16 - tib));
      c   = {{48{pat[15]}}, pat} + (64'sd1 <<< (15 - tib));
      mag = (c < 0) ? 64'(-c) : 64'(c);
      if (!use_tanh) begin
         e = ndpa_exp_neg(mag, frac);
         d = (64'd1 << 40) + e;
         if (c >= 0) begin
            s = ndpa_udiv((64'd1 << (frac + 40)) + (d >> 1), d);
         end else begin
            s = ndpa_udiv((e << frac) + (d >> 1), d);
         end
         res = ndpa_clamp_pos(s);
      end else begin
         e = ndpa_exp_neg(mag << 1, frac);
         d = (64'd1 << 40) + e;
         t = {48'd0, ndpa_clamp_pos(ndpa_udiv((((64'd1 << 40) - e) << frac) + (d >> 1), d))};
         res = (c < 0) ? 16'(17'h10000 - t[16:0]) : t[15:0];
      end
      return res;
   endfunction

endpackage

FILE: src/ndpa_front.sv
// ----------------------------------------------------------------------------
// ndpa_front
// Input side: takes one value/weight pair per transfer, forms the product
// and tags it with the end-of-vector flag for the queue.
// ----------------------------------------------------------------------------
module ndpa_front (
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [31:0]             req_tdata,   // [15:0] input_value, [31:16] weight_value
   input  logic                    req_tlast,   // last_input
   input  ndpa_pkg::ndpa_qstat_type qstat,
   output logic                    push_valid,
   output ndpa_pkg::ndpa_entry_type push_entry
);
   import ndpa_pkg::*;

   logic signed [VAL_W-1:0] in_val;
   logic signed [VAL_W-1:0] wt_val;
   logic                    vec_end;

   // field split
   assign in_val  = signed'(req_tdata[VAL_W-1:0]);
   assign wt_val  = signed'(req_tdata[2*VAL_W-1:VAL_W]);
   assign vec_end = req_tlast;

   // accept whenever the queue has room
   assign req_tready = !qstat.full;
   assign push_valid = req_tvalid && !qstat.full;

   // product lands in the queue register
   assign push_entry.prod = PROD_W'(in_val * wt_val);
   assign push_entry.last = vec_end;

endmodule

FILE: src/ndpa_queue.sv
// ----------------------------------------------------------------------------
// ndpa_queue
// Small register queue between the multiply front and the accumulate back.
// ----------------------------------------------------------------------------
module ndpa_queue #(
   parameter int DEPTH = ndpa_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  ndpa_pkg::ndpa_entry_type push_entry,
   input  logic                     pop_ready,
   output ndpa_pkg::ndpa_entry_type pop_entry,
   output ndpa_pkg::ndpa_qstat_type qstat
);
   import ndpa_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ndpa_entry_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   // status
   assign qstat.full  = (count_ff == FULL_CNT);
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push_valid && !qstat.full;
   assign do_pop      = pop_ready && !qstat.empty;
   assign pop_entry   = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: src/ndpa_back.sv
// ----------------------------------------------------------------------------
// ndpa_back
// Accumulates queued products with saturation; at the end of a vector subtracts
// the bias, rounds, selects the activation and holds the result.
// ----------------------------------------------------------------------------
`include "neuron_dot_product_activation_defines.svh"

module ndpa_back #(
   parameter int FRAC_BITS        = ndpa_pkg::FRAC_BITS_DEF,
   parameter int TABLE_INDEX_BITS = ndpa_pkg::TABLE_INDEX_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ndpa_pkg::ndpa_qstat_type qstat,
   input  ndpa_pkg::ndpa_entry_type pop_entry,
   output logic                     pop_ready,
   input  ndpa_pkg::ndpa_cfg_type   cfg,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [63:0]              rsp_tdata    // [47:0] pre_activation, [63:48] activated
);
   import ndpa_pkg::*;

   localparam int ROM_SIZE = 1 << TABLE_INDEX_BITS;
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [ACC_W:0]   HALF_LSB = (ACC_W+1)'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [ACC_W:0]   X_MAX = 49'sd32767;
   localparam logic signed [ACC_W:0]   X_MIN = -49'sd32768;
   localparam logic [15:0] STEP_POS = (FRAC_BITS >= 15) ? 16'h7FFF : 16'(1 << FRAC_BITS);
   localparam logic [15:0] STEP_NEG = 16'(-(32'sd1 <<< FRAC_BITS));

   // activation tables
   logic [15:0] sig_tbl  [ROM_SIZE];
   logic [15:0] tanh_tbl [ROM_SIZE];

   for (genvar gi = 0; gi < ROM_SIZE; gi++) begin : g_rom
      localparam logic [15:0] SIG_ENTRY  = ndpa_rom_entry(gi, 1'b0, FRAC_BITS, TABLE_INDEX_BITS);
      localparam logic [15:0] TANH_ENTRY = ndpa_rom_entry(gi, 1'b1, FRAC_BITS, TABLE_INDEX_BITS);
      assign sig_tbl[gi]  = SIG_ENTRY;
      assign tanh_tbl[gi] = TANH_ENTRY;
   end

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] s1_sum_ff, s2_pre_ff, s3_pre_ff, out_pre_ff;
   logic signed [15:0]      s3_x_ff;
   logic [15:0]             sig_rd_ff, tanh_rd_ff;
   logic [15:0]             out_act_ff;
   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic                    s1_valid_in, s2_valid_in, s3_valid_in, out_valid_in;
   logic                    pop_fire, s1_free, s2_free, s3_free, out_free;
   logic                    s2_load, s3_load, out_load, s3_adv;
   logic signed [ACC_W:0]   sum_wide, diff_wide, rnd_wide, x_wide;
   logic signed [ACC_W-1:0] sum_sat, pre_sat;
   logic signed [15:0]      x_sat;
   logic [TABLE_INDEX_BITS-1:0] tbl_idx;
   logic [15:0]             act_sel;

   // stage hand-off
   assign out_free = !out_valid_ff || rsp_tready;
   assign s3_free  = !s3_valid_ff || out_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign pop_ready = !pop_entry.last || s1_free;
   assign pop_fire  = pop_ready && !qstat.empty;
   assign s2_load   = s1_valid_ff && s2_free;
   assign s3_load   = s2_valid_ff && s3_free;
   assign s3_adv    = s3_valid_ff && out_free;
   assign out_load  = s3_adv;

   // saturating accumulate
   assign sum_wide = {acc_ff[ACC_W-1], acc_ff} + (ACC_W+1)'(pop_entry.prod);
   assign sum_sat  = (sum_wide[ACC_W] != sum_wide[ACC_W-1]) ?
                     (sum_wide[ACC_W] ? ACC_MIN : ACC_MAX) : sum_wide[ACC_W-1:0];

   always_comb begin
      acc_in = acc_ff;
      if (pop_fire) begin
         acc_in = pop_entry.last ? '0 : sum_sat;
      end
   end

   // bias term: fixed input of minus one times the bias weight
   assign diff_wide = {s1_sum_ff[ACC_W-1], s1_sum_ff}
                      - ((ACC_W+1)'(cfg.bias) <<< FRAC_BITS);
   assign pre_sat   = (diff_wide[ACC_W] != diff_wide[ACC_W-1]) ?
                      (diff_wide[ACC_W] ? ACC_MIN : ACC_MAX) : diff_wide[ACC_W-1:0];

   // round half up to the value format and clamp
   assign rnd_wide = {s2_pre_ff[ACC_W-1], s2_pre_ff} + HALF_LSB;
   assign x_wide   = rnd_wide >>> FRAC_BITS;
   always_comb begin
      if (x_wide > X_MAX) begin
         x_sat = 16'sh7FFF;
      end else if (x_wide < X_MIN) begin
         x_sat = -16'sh8000;
      end else begin
         x_sat = x_wide[15:0];
      end
   end

   // table address from the clamped value, data registered with stage 3
   assign tbl_idx = x_sat[15 -: TABLE_INDEX_BITS];

   // activation select
   always_comb begin
      unique case (cfg.mode)
         MODE_SIGMOID:  act_sel = sig_rd_ff;
         MODE_STEP:     act_sel = s3_x_ff[15] ? STEP_NEG : STEP_POS;
         MODE_TANH:     act_sel = tanh_rd_ff;
         MODE_IDENTITY: act_sel = s3_x_ff;
         default:       act_sel = s3_x_ff;
      endcase
   end

   // valid bits
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s2_valid_in  = s2_valid_ff;
      s3_valid_in  = s3_valid_ff;
      out_valid_in = out_valid_ff;
      if (pop_fire && pop_entry.last) begin
         s1_valid_in = 1'b1;
      end else if (s2_free) begin
         s1_valid_in = 1'b0;
      end
      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (s3_free) begin
         s2_valid_in = 1'b0;
      end
      if (s3_load) begin
         s3_valid_in = 1'b1;
      end else if (out_free) begin
         s3_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (pop_fire && pop_entry.last) begin
         s1_sum_ff <= sum_sat;
      end
      if (s2_load) begin
         s2_pre_ff <= pre_sat;
      end
      if (s3_load) begin
         s3_pre_ff  <= s2_pre_ff;
         s3_x_ff    <= x_sat;
         sig_rd_ff  <= sig_tbl[tbl_idx];
         tanh_rd_ff <= tanh_tbl[tbl_idx];
      end
      if (out_load) begin
         out_pre_ff <= s3_pre_ff;
         out_act_ff <= act_sel;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_act_ff, out_pre_ff};

   // checks
   `NDPA_ASSERT_NEXT(a_clear_after_last, clock, reset, pop_fire && pop_entry.last, acc_ff == '0)
   `NDPA_ASSERT_NEXT(a_out_drains, clock, reset, rsp_tvalid && rsp_tready && !s3_adv, !rsp_tvalid)
   `NDPA_ASSERT_IMPL(a_s1_from_last, clock, reset, $rose(s1_valid_ff), $past(pop_fire && pop_entry.last))

endmodule

FILE: src/neuron_dot_product_activation.sv
// ----------------------------------------------------------------------------
// neuron_dot_product_activation
// Result: rsp_tvalid rises once the last input has passed the queue, the sum,
// bias, round and table read, and output registers.
// Throughput: one input transfer per cycle while the queue is not full, set by
// the combinational multiply and the saturating accumulate; one result per vector.
// Reset: synchronous, clears the accumulator, queue, stage valids, mode and bias registers.
// ----------------------------------------------------------------------------
module neuron_dot_product_activation #(
   parameter int FRAC_BITS        = ndpa_pkg::FRAC_BITS_DEF,
   parameter int TABLE_INDEX_BITS = ndpa_pkg::TABLE_INDEX_BITS_DEF,
   parameter int QUEUE_DEPTH      = ndpa_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] input_value, [31:16] weight_value
   input  logic        req_tlast,    // last_input
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [47:0] pre_activation, [63:48] activated
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ndpa_pkg::*;

   ndpa_mode_type      mode_ff, mode_in;
   logic signed [15:0] bias_ff, bias_in;
   logic               csr_wr;
   logic               reg_sel;
   ndpa_cfg_type       cfg;
   ndpa_qstat_type     qstat;
   ndpa_entry_type     push_entry, pop_entry;
   logic               push_valid, pop_ready;

   // register access
   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_in = mode_ff;
      bias_in = bias_ff;
      if (csr_wr) begin
         unique case (reg_sel)
            REG_MODE: mode_in = ndpa_mode_type'(csr_pwdata[1:0]);
            REG_BIAS: bias_in = signed'(csr_pwdata[15:0]);
            default:  mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SIGMOID;
         bias_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         bias_ff <= bias_in;
      end
   end

   assign csr_prdata = (reg_sel == REG_BIAS) ? {16'd0, bias_ff} : {30'd0, mode_ff};
   assign cfg.mode   = mode_ff;
   assign cfg.bias   = bias_ff;

   // multiply front
   ndpa_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .qstat      (qstat),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // decoupling queue
   ndpa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .qstat      (qstat)
   );

   // accumulate and activation back end
   ndpa_back #(
      .FRAC_BITS        (FRAC_BITS),
      .TABLE_INDEX_BITS (TABLE_INDEX_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready),
      .cfg        (cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
